@@ rtl/core/spf_pkg.sv @@
// Shared types and constants for the sample packet framer.
package spf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SEQ_W = 8;
    localparam int TRIG_W = 16;
    localparam int BYTE_W = 8;
    localparam int S_TDATA_W = 56;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W = 5;

    localparam logic [BYTE_W-1:0] SYNC0 = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC1 = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC2 = 8'h5A;
    localparam logic [BYTE_W-1:0] SYNC3 = 8'hA5;
    localparam logic [BYTE_W-1:0] HDR_SIZE_CODE = 8'd12;
    localparam logic [BYTE_W-1:0] PKTS_IN_SEQ = 8'd1;
    localparam logic [TRIG_W-1:0] NO_TRIGGER = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_TYPE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPC = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAN = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE = 3'd6;

    localparam logic [POS_W-1:0] POS_SYNC0 = 5'd0;
    localparam logic [POS_W-1:0] POS_SYNC1 = 5'd1;
    localparam logic [POS_W-1:0] POS_SYNC2 = 5'd2;
    localparam logic [POS_W-1:0] POS_SYNC3 = 5'd3;
    localparam logic [POS_W-1:0] POS_TYPE = 5'd4;
    localparam logic [POS_W-1:0] POS_SIZE = 5'd5;
    localparam logic [POS_W-1:0] POS_REP = 5'd6;
    localparam logic [POS_W-1:0] POS_PKTS = 5'd7;
    localparam logic [POS_W-1:0] POS_SEQ = 5'd8;
    localparam logic [POS_W-1:0] POS_CLASS = 5'd9;
    localparam logic [POS_W-1:0] POS_SPC_HI = 5'd10;
    localparam logic [POS_W-1:0] POS_SPC_LO = 5'd11;
    localparam logic [POS_W-1:0] POS_RATE_HI = 5'd12;
    localparam logic [POS_W-1:0] POS_RATE_LO = 5'd13;
    localparam logic [POS_W-1:0] POS_TRIG_HI = 5'd14;
    localparam logic [POS_W-1:0] POS_TRIG_LO = 5'd15;
    localparam logic [POS_W-1:0] POS_CHAN = 5'd16;
    localparam logic [POS_W-1:0] POS_SUM = 5'd17;
    localparam logic [POS_W-1:0] POS_S3 = 5'd18;
    localparam logic [POS_W-1:0] POS_S2 = 5'd19;
    localparam logic [POS_W-1:0] POS_S1 = 5'd20;
    localparam logic [POS_W-1:0] POS_S0 = 5'd21;

    typedef struct packed {
        logic [BYTE_W-1:0] type_code;
        logic [BYTE_W-1:0] rep_code;
        logic              wide;
        logic [BYTE_W-1:0] class_code;
        logic [15:0]       samples_per_channel;
        logic [BYTE_W-1:0] channel_count;
        logic [15:0]       sample_rate;
    } cfg_t;

    typedef struct packed {
        logic                first;
        logic [SEQ_W-1:0]    seq;
        logic [TRIG_W-1:0]   trig;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

endpackage

@@ rtl/core/spf_front.sv @@
// Front end: configuration registers and unpacking of accepted samples into queue commands.
module spf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spf_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output spf_pkg::cmd_t                       q_cmd,
    output spf_pkg::cfg_t                       cfg
);
    import spf_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.type_code <= '0;
            cfg_reg.rep_code <= '0;
            cfg_reg.wide <= 1'b1;
            cfg_reg.class_code <= '0;
            cfg_reg.samples_per_channel <= 16'd16;
            cfg_reg.channel_count <= 8'd4;
            cfg_reg.sample_rate <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TYPE:  cfg_reg.type_code <= cfg_data[BYTE_W-1:0];
                REG_REP:   cfg_reg.rep_code <= cfg_data[BYTE_W-1:0];
                REG_WIDE:  cfg_reg.wide <= cfg_data[0];
                REG_CLASS: cfg_reg.class_code <= cfg_data[BYTE_W-1:0];
                REG_SPC:   cfg_reg.samples_per_channel <= cfg_data;
                REG_CHAN:  cfg_reg.channel_count <= cfg_data[BYTE_W-1:0];
                REG_RATE:  cfg_reg.sample_rate <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full;

    always_comb begin
        q_cmd.first = s_tuser;
        q_cmd.sample = s_tdata[SAMPLE_W-1:0];
        q_cmd.seq = s_tdata[SAMPLE_W+SEQ_W-1:SAMPLE_W];
        q_cmd.trig = s_tdata[SAMPLE_W+SEQ_W+TRIG_W-1:SAMPLE_W+SEQ_W];
    end

endmodule

@@ rtl/core/spf_queue.sv @@
// Short command queue between the front end and the byte serializer.
module spf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  spf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output spf_pkg::cmd_t head_cmd
);
    import spf_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/spf_back.sv @@
// Back end: walks each command through its header and sample bytes into the output register.
module spf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  spf_pkg::cfg_t               cfg,
    input  logic                        q_not_empty,
    input  spf_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [spf_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import spf_pkg::*;

    cmd_t              cmd_reg, cmd_next;
    logic              active_reg, active_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              advance;
    logic              is_last;
    logic              load;
    logic [BYTE_W-1:0] cur_byte;
    logic [TRIG_W-1:0] trig_field;

    assign advance = !m_tvalid_reg || m_tready;
    assign is_last = (pos_reg == POS_S0);
    assign load = advance && q_not_empty && (!active_reg || is_last);
    assign q_pop = load;
    assign trig_field = cfg.wide ? cmd_reg.trig : NO_TRIGGER;

    always_comb begin
        unique case (pos_reg)
            POS_SYNC0:   cur_byte = SYNC0;
            POS_SYNC1:   cur_byte = SYNC1;
            POS_SYNC2:   cur_byte = SYNC2;
            POS_SYNC3:   cur_byte = SYNC3;
            POS_TYPE:    cur_byte = cfg.type_code;
            POS_SIZE:    cur_byte = HDR_SIZE_CODE;
            POS_REP:     cur_byte = cfg.rep_code;
            POS_PKTS:    cur_byte = PKTS_IN_SEQ;
            POS_SEQ:     cur_byte = cmd_reg.seq;
            POS_CLASS:   cur_byte = cfg.class_code;
            POS_SPC_HI:  cur_byte = cfg.samples_per_channel[15:8];
            POS_SPC_LO:  cur_byte = cfg.samples_per_channel[7:0];
            POS_RATE_HI: cur_byte = cfg.sample_rate[15:8];
            POS_RATE_LO: cur_byte = cfg.sample_rate[7:0];
            POS_TRIG_HI: cur_byte = trig_field[15:8];
            POS_TRIG_LO: cur_byte = trig_field[7:0];
            POS_CHAN:    cur_byte = cfg.channel_count;
            POS_SUM:     cur_byte = sum_reg;
            POS_S3:      cur_byte = cmd_reg.sample[31:24];
            POS_S2:      cur_byte = cmd_reg.sample[23:16];
            POS_S1:      cur_byte = cmd_reg.sample[15:8];
            POS_S0:      cur_byte = cmd_reg.sample[7:0];
            default:     cur_byte = '0;
        endcase
    end

    always_comb begin
        cmd_next = cmd_reg;
        active_next = active_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        m_tlast_next = m_tlast_reg;
        if (advance) begin
            m_tvalid_next = active_reg;
            m_tdata_next = cur_byte;
            m_tlast_next = is_last;
            if (active_reg) begin
                if (pos_reg >= POS_TYPE && pos_reg <= POS_CHAN) begin
                    sum_next = sum_reg + cur_byte;
                end
                if (pos_reg == POS_SUM && !cfg.wide) begin
                    pos_next = POS_S1;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
                if (is_last) begin
                    active_next = 1'b0;
                end
            end
            if (load) begin
                cmd_next = q_cmd;
                active_next = 1'b1;
                sum_next = '0;
                priority if (q_cmd.first) begin
                    pos_next = POS_SYNC0;
                end else if (cfg.wide) begin
                    pos_next = POS_S3;
                end else begin
                    pos_next = POS_S1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        sum_reg <= sum_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

endmodule

@@ rtl/core/sample_packet_framer.sv @@
// Top level of the sample packet framer.
// The framer turns each accepted sample into a burst of bytes on the master stream, one byte
// per clock cycle while the sink keeps tready high: 4 bytes for a 32-bit sample or 2 for a
// 16-bit sample, and 18 more (sync, header fields, checksum) when tuser marks the first sample
// of a packet. The byte rate is set by the single byte-wide output register of the
// serializer; a two-entry queue lets the next samples be accepted while the current one is
// still going out, and consecutive items follow with no gap. tlast marks the final byte of
// each item. Configuration writes take effect at once and are meant to be made while no
// item is in flight.
module sample_packet_framer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_value[31:0], sequence_number[39:32], trigger_position[55:40]
    input  logic [spf_pkg::S_TDATA_W-1:0]       s_tdata,
    // first_of_packet
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_byte[7:0]
    output logic [spf_pkg::BYTE_W-1:0]          m_tdata,
    output logic                                m_tlast
);
    import spf_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;

    spf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .cfg       (cfg)
    );

    spf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    spf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ rtl/core/spf_checker.sv @@
// Port-level checks for the sample packet framer and the bind that attaches them.
module spf_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [spf_pkg::BYTE_W-1:0]          m_tdata,
    input logic                                m_tlast
);
    import spf_pkg::*;

    logic [3:0] pending_reg;
    logic       in_xfer;
    logic       out_end;

    assign in_xfer = s_tvalid && s_tready;
    assign out_end = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_xfer && !out_end) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (out_end && !in_xfer) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("output byte without an outstanding sample");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'd4)
        else $error("more samples in flight than the framer can hold");

endmodule

bind sample_packet_framer spf_checker u_spf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
